// ----- design/ccss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ccss_pkg;

	// One result word, as it leaves the block
	typedef struct packed {
		logic       text_end;
		logic       last_of_run;
		logic       has_byte;
		logic [7:0] out_byte;
	} res_t;

	// Results of one input byte, handed from the scanner to the output queue
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage
`default_nettype wire

// ----- design/c_comment_strip_space_squash.sv -----
`timescale 1ns / 1ps
`default_nettype none
// C comment stripper with space squashing.
// Slave channel s_*: one source byte per word, s_tlast marks the last byte of
// a text; a zero byte also ends the text.
// Master channel m_*: one output word per kept character. m_tuser[0] is
// has_byte (0 for a bare end marker), m_tuser[1] marks the last word caused
// by one input byte, m_tlast marks the final word of the text.
// A byte is registered on acceptance and its words are written to a
// four-entry output queue once the queue has room, and the queue offers
// them from its registers. Throughput is one input byte per cycle while the
// queue has room; a byte other than a zero byte that releases a held slash
// yields two words, and the single-word output side then sets the pace.
// An input byte moves on only when the queue has room for two words, so a
// stalled receiver backs up into s_tready after at most four queued words.
// Reset clears the scanner to normal text and empties the queue.
module c_comment_strip_space_squash (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // in_byte
	input  wire logic       s_tlast,   // end_of_text
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // out_byte
	output logic [1:0]      m_tuser,   // has_byte, last_of_run
	output logic            m_tlast    // text_end
);
	import ccss_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       room;
	logic       adv;
	push_t      push;
	push_t      push_gated;

	assign adv      = valid_s1 && room;
	assign s_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	ccss_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ch     (byte_s1),
		.eot    (eot_s1),
		.push   (push)
	);

	// Push only for a byte that moves on
	always_comb begin
		push_gated = push;
		if (!adv) push_gated.n = 2'd0;
	end

	ccss_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_gated),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ----- design/ccss_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ccss_step (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         adv,
	input  wire logic [7:0]   ch,
	input  wire logic         eot,
	output ccss_pkg::push_t   push
);
	import ccss_pkg::*;

	localparam logic [2:0] M_NORMAL = 3'd0;
	localparam logic [2:0] M_SLASH  = 3'd1;
	localparam logic [2:0] M_LINE   = 3'd2;
	localparam logic [2:0] M_BLOCK  = 3'd3;
	localparam logic [2:0] M_BSTAR  = 3'd4;
	localparam logic [2:0] M_DQ     = 3'd5;
	localparam logic [2:0] M_SQ     = 3'd6;

	localparam logic [7:0] C_NUL   = 8'h00;
	localparam logic [7:0] C_SLASH = 8'h2F;
	localparam logic [7:0] C_STAR  = 8'h2A;
	localparam logic [7:0] C_BSL   = 8'h5C;
	localparam logic [7:0] C_DQ    = 8'h22;
	localparam logic [7:0] C_SQ    = 8'h27;
	localparam logic [7:0] C_TAB   = 8'h09;
	localparam logic [7:0] C_NL    = 8'h0A;
	localparam logic [7:0] C_SP    = 8'h20;

	typedef struct packed {
		logic       emit;
		logic [7:0] ch;
		logic [2:0] mode;
		logic       clr_par;
	} plain_t;

	logic [2:0] mode_q;
	logic       par_q;
	logic       ls_q;

	logic [2:0] mode_d;
	logic       par_d;
	logic       ls_d;
	logic       finish;
	logic       ea, eb, ec;
	logic [7:0] bb;
	plain_t     pt;
	res_t       ra, rb, rc;

	// Handle one byte of ordinary text
	function automatic plain_t plain(input logic [7:0] c, input logic ls);
		plain_t p;
		p.emit    = 1'b0;
		p.ch      = c;
		p.mode    = M_NORMAL;
		p.clr_par = 1'b0;
		if (c == C_SLASH) begin
			p.mode = M_SLASH;
		end else if (c == C_DQ) begin
			p.emit    = 1'b1;
			p.mode    = M_DQ;
			p.clr_par = 1'b1;
		end else if (c == C_SQ) begin
			p.emit    = 1'b1;
			p.mode    = M_SQ;
			p.clr_par = 1'b1;
		end else if (c == C_SP || c == C_TAB) begin
			p.emit = !ls;
			p.ch   = C_SP;
		end else begin
			p.emit = 1'b1;
		end
		return p;
	endfunction

	// Scan the byte: next state and up to three candidate emissions
	always_comb begin
		finish = eot || (ch == C_NUL);
		mode_d = mode_q;
		par_d  = par_q;
		ls_d   = ls_q;
		ea     = 1'b0;
		eb     = 1'b0;
		ec     = 1'b0;
		bb     = ch;
		pt     = plain(ch, ls_q);
		if (ch != C_NUL) begin
			case (mode_q)
				M_SLASH: begin
					if (ch == C_SLASH) begin
						mode_d = M_LINE;
					end else if (ch == C_STAR) begin
						mode_d = M_BLOCK;
					end else begin
						ea     = 1'b1;
						pt     = plain(ch, 1'b0);
						eb     = pt.emit;
						bb     = pt.ch;
						mode_d = pt.mode;
						if (pt.clr_par) par_d = 1'b0;
						ls_d   = pt.emit ? (pt.ch == C_SP) : 1'b0;
					end
				end
				M_LINE: begin
					if (ch == C_NL) mode_d = M_NORMAL;
				end
				M_BLOCK: begin
					if (ch == C_STAR) mode_d = M_BSTAR;
				end
				M_BSTAR: begin
					if (ch == C_SLASH) mode_d = M_NORMAL;
					else if (ch != C_STAR) mode_d = M_BLOCK;
				end
				M_DQ, M_SQ: begin
					eb   = 1'b1;
					ls_d = (ch == C_SP);
					if (ch == C_BSL) begin
						par_d = !par_q;
					end else begin
						if (ch == ((mode_q == M_DQ) ? C_DQ : C_SQ) && !par_q)
							mode_d = M_NORMAL;
						par_d = 1'b0;
					end
				end
				default: begin
					eb     = pt.emit;
					bb     = pt.ch;
					mode_d = pt.mode;
					if (pt.clr_par) par_d = 1'b0;
					if (pt.emit) ls_d = (pt.ch == C_SP);
				end
			endcase
		end
		// Flush a held slash at end of text, then drop back to reset state
		if (finish) begin
			ec     = (mode_d == M_SLASH);
			mode_d = M_NORMAL;
			par_d  = 1'b0;
			ls_d   = 1'b0;
		end
	end

	// Pack the emissions in order, mark the last one
	always_comb begin
		ra = '{text_end: 1'b0, last_of_run: 1'b0, has_byte: 1'b1, out_byte: C_SLASH};
		rb = '{text_end: 1'b0, last_of_run: 1'b0, has_byte: 1'b1, out_byte: bb};
		rc = ra;
		push.n  = 2'({1'b0, ea} + {1'b0, eb} + {1'b0, ec});
		push.r1 = '0;
		if (ea) begin
			push.r0 = ra;
			push.r1 = eb ? rb : rc;
		end else if (eb) begin
			push.r0 = rb;
			push.r1 = rc;
		end else begin
			push.r0 = rc;
		end
		if (finish && push.n == 2'd0) begin
			push.r0 = '0;
			push.n  = 2'd1;
		end
		if (push.n == 2'd1) begin
			push.r0.last_of_run = 1'b1;
			push.r0.text_end    = finish;
		end else if (push.n == 2'd2) begin
			push.r1.last_of_run = 1'b1;
			push.r1.text_end    = finish;
		end
	end

	// Advance scanner state when the byte is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			par_q  <= 1'b0;
			ls_q   <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_d;
			par_q  <= par_d;
			ls_q   <= ls_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/ccss_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ccss_outq (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ccss_pkg::push_t push,
	output logic              room,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [7:0]        m_tdata,  // out_byte
	output logic [1:0]        m_tuser,  // has_byte, last_of_run
	output logic              m_tlast   // text_end
);
	import ccss_pkg::*;

	res_t       mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       pop;
	res_t       head;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 3'd0);
	assign head     = mem_q[rp_q];
	assign m_tdata  = head.out_byte;
	assign m_tuser  = {head.last_of_run, head.has_byte};
	assign m_tlast  = head.text_end;
	// Room for two more words after this cycle's pop
	assign room     = (cnt_q <= 3'd2) || (cnt_q == 3'd3 && pop);

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wp_q] <= push.r0;
		if (push.n == 2'd2) mem_q[wp_q + 2'd1] <= push.r1;
	end

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + push.n;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.n} - {2'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> (cnt_q + {1'b0, push.n} - {2'b0, pop}) <= 3'd4)
		else $error("output queue overflow");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("output queue count out of range");

	a_two_push: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 && !pop |=> cnt_q == $past(cnt_q) + 3'd2)
		else $error("double push not counted");

endmodule
`default_nettype wire
